// ----- rtl/core/rbb_pkg.sv -----
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the RGB box blur
// Word formats, configuration register indexes, back-end states and reset
// values used by the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package rbb_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;
  localparam int MAX_KERNEL_DEF = 15;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int KSIZE_W    = 4;
  localparam int DIM_W      = 11;
  localparam int PIX_W      = 24;

  localparam logic [KSIZE_W-1:0] KSIZE_RST  = 4'd3;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd1024;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DIV,
    B_OUT
  } back_state_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } rbb_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       last_of_frame;
  } rbb_out_t;

  // window rows plus the rows still read by up to three queued or active jobs
  function automatic int ring_rows(input int max_kernel);
    ring_rows = max_kernel + 4;
  endfunction

  function automatic int job_bits(input int max_width, input int max_kernel);
    job_bits = 2 * $clog2(max_width) + $clog2(ring_rows(max_kernel)) + KSIZE_W + 1;
  endfunction

endpackage

// ----- rtl/core/rbb_front.sv -----
// ----------------------------------------------------------------------------
// rbb_front: input side of the box blur
// Holds the configuration, tracks input and output positions, writes pixels
// to the line store and queues one window job per output that becomes ready.
// ----------------------------------------------------------------------------
module rbb_front #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_KERNEL = rbb_pkg::MAX_KERNEL_DEF,
  parameter int JOB_W      = rbb_pkg::job_bits(MAX_WIDTH, MAX_KERNEL)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbb_pkg::rbb_in_t               in_item,
  input  logic                           q_full,
  output logic                           q_push,
  output logic [JOB_W-1:0]               q_data,
  output logic                           wr_en,
  output logic [$clog2(rbb_pkg::ring_rows(MAX_KERNEL))-1:0] wr_ring,
  output logic [$clog2(MAX_WIDTH)-1:0]   wr_col,
  output logic [rbb_pkg::PIX_W-1:0]      wr_pix
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int YW   = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int RING = rbb_pkg::ring_rows(MAX_KERNEL);
  localparam int RW   = $clog2(RING);
  localparam int KW   = rbb_pkg::KSIZE_W;

  typedef struct packed {
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [RW-1:0] ring0;
    logic [KW-1:0] nrow;
    logic          last;
  } job_t;

  logic [KW-1:0]               ksize;
  logic [rbb_pkg::DIM_W-1:0]   image_width;
  logic [rbb_pkg::DIM_W-1:0]   image_height;

  logic [XW-1:0] in_col;
  logic [HW-1:0] in_row;
  logic [RW-1:0] in_ring;
  logic [XW-1:0] out_col;
  logic [YW-1:0] out_row;
  logic [RW-1:0] out_ring;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [KW-1:0] k_eff, hi, lo;
  logic          take, pix;
  logic [XW-1:0] col_u;
  logic [HW-1:0] row_u;
  logic [RW-1:0] ring_u;
  logic [YW:0]   row_sum;
  logic [XW:0]   col_sum;
  logic [YW-1:0] lastr, y0, h_m1;
  logic [XW-1:0] lastc, x0, w_m1;
  logic [KW-1:0] dy;
  logic [RW:0]   ring0_w;
  logic          ready, last;
  job_t          job;

  always_comb begin
    if (image_width == '0) begin
      w_eff = WW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
    if (ksize == '0) begin
      k_eff = KW'(1);
    end else if (32'(ksize) > MAX_KERNEL) begin
      k_eff = KW'(MAX_KERNEL);
    end else begin
      k_eff = ksize;
    end
    hi = k_eff >> 1;
    lo = (k_eff - KW'(1)) >> 1;
    w_m1 = XW'(w_eff - WW'(1));
    h_m1 = YW'(h_eff - HW'(1));
  end

  assign in_stall = q_full;
  assign take     = in_valid && !in_stall;
  assign pix      = take && !in_item.mode && (in_row < h_eff);

  assign wr_en   = pix;
  assign wr_ring = in_ring;
  assign wr_col  = in_col;
  assign wr_pix  = {in_item.in_blue, in_item.in_green, in_item.in_red};

  always_comb begin
    col_u  = in_col;
    row_u  = in_row;
    ring_u = in_ring;
    if (pix) begin
      if (WW'(in_col) + WW'(1) >= w_eff) begin
        col_u  = '0;
        row_u  = in_row + HW'(1);
        ring_u = (32'(in_ring) == RING - 1) ? '0 : in_ring + RW'(1);
      end else begin
        col_u = in_col + XW'(1);
      end
    end

    row_sum = {1'b0, out_row} + (YW + 1)'(hi);
    col_sum = {1'b0, out_col} + (XW + 1)'(hi);
    lastr   = (row_sum > {1'b0, h_m1}) ? h_m1 : row_sum[YW-1:0];
    lastc   = (col_sum > {1'b0, w_m1}) ? w_m1 : col_sum[XW-1:0];
    ready   = take && ((row_u > HW'(lastr)) || (row_u == HW'(lastr) && col_u > lastc));

    y0 = (out_row >= YW'(lo)) ? out_row - YW'(lo) : '0;
    x0 = (out_col >= XW'(lo)) ? out_col - XW'(lo) : '0;
    dy = KW'(out_row - y0);
    if ((RW + 1)'(out_ring) >= (RW + 1)'(dy)) begin
      ring0_w = (RW + 1)'(out_ring) - (RW + 1)'(dy);
    end else begin
      ring0_w = (RW + 1)'(out_ring) + (RW + 1)'(RING) - (RW + 1)'(dy);
    end
    last = (out_col == w_m1) && (out_row == h_m1);

    job.x0    = x0;
    job.x1    = lastc;
    job.ring0 = ring0_w[RW-1:0];
    job.nrow  = KW'(lastr - y0);
    job.last  = last;
  end

  assign q_push = ready;
  assign q_data = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      ksize        <= rbb_pkg::KSIZE_RST;
      image_width  <= rbb_pkg::WIDTH_RST;
      image_height <= rbb_pkg::HEIGHT_RST;
      in_col       <= '0;
      in_row       <= '0;
      in_ring      <= '0;
      out_col      <= '0;
      out_row      <= '0;
      out_ring     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbb_pkg::CFG_KERNEL_SIZE:  ksize        <= cfg_data[KW-1:0];
        rbb_pkg::CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        rbb_pkg::CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
      if (cfg_index == rbb_pkg::CFG_KERNEL_SIZE || cfg_index == rbb_pkg::CFG_IMAGE_WIDTH ||
          cfg_index == rbb_pkg::CFG_IMAGE_HEIGHT) begin
        in_col   <= '0;
        in_row   <= '0;
        in_ring  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_ring <= '0;
      end
    end else if (take) begin
      if (ready && last) begin
        in_col   <= '0;
        in_row   <= '0;
        in_ring  <= '0;
        out_col  <= '0;
        out_row  <= '0;
        out_ring <= '0;
      end else begin
        in_col  <= col_u;
        in_row  <= row_u;
        in_ring <= ring_u;
        if (ready) begin
          if (out_col == w_m1) begin
            out_col  <= '0;
            out_row  <= out_row + YW'(1);
            out_ring <= (32'(out_ring) == RING - 1) ? '0 : out_ring + RW'(1);
          end else begin
            out_col <= out_col + XW'(1);
          end
        end
      end
    end
  end

endmodule

// ----- rtl/core/rbb_queue.sv -----
// ----------------------------------------------------------------------------
// rbb_queue: two-entry job queue
// Show-ahead FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module rbb_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] head
);

  logic [DW-1:0] slot [2];
  logic          wp, rp;
  logic [1:0]    count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = slot[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wp] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ----- rtl/core/rbb_back.sv -----
// ----------------------------------------------------------------------------
// rbb_back: window engine of the box blur
// Owns the line store, sums one window a pixel per cycle, divides the three
// sums by the pixel count one quotient bit per cycle and holds the result.
// ----------------------------------------------------------------------------
module rbb_back #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = rbb_pkg::MAX_KERNEL_DEF,
  parameter int JOB_W      = rbb_pkg::job_bits(MAX_WIDTH, MAX_KERNEL)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [$clog2(rbb_pkg::ring_rows(MAX_KERNEL))-1:0] wr_ring,
  input  logic [$clog2(MAX_WIDTH)-1:0]    wr_col,
  input  logic [rbb_pkg::PIX_W-1:0]       wr_pix,
  input  logic                            q_empty,
  input  logic [JOB_W-1:0]                q_head,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rbb_pkg::rbb_out_t               out_item
);

  localparam int XW   = $clog2(MAX_WIDTH);
  localparam int RING = rbb_pkg::ring_rows(MAX_KERNEL);
  localparam int RW   = $clog2(RING);
  localparam int KW   = rbb_pkg::KSIZE_W;
  localparam int SW   = $clog2(MAX_KERNEL * MAX_KERNEL * 255 + 1);
  localparam int CNTW = $clog2(MAX_KERNEL * MAX_KERNEL + 1);
  localparam int DCW  = $clog2(SW + 1);

  typedef struct packed {
    logic [XW-1:0] x0;
    logic [XW-1:0] x1;
    logic [RW-1:0] ring0;
    logic [KW-1:0] nrow;
    logic          last;
  } job_t;

  logic [rbb_pkg::PIX_W-1:0] mem [RING][MAX_WIDTH];
  logic [rbb_pkg::PIX_W-1:0] rd_data;

  rbb_pkg::back_state_t state, state_next;
  job_t          job;
  logic [XW-1:0] cur_x, x0r, x1r;
  logic [RW-1:0] cur_ring;
  logic [KW-1:0] rows_left;
  logic          issue_done, rd_pend, issue, last_r;
  logic [CNTW-1:0] cnt;
  logic [SW-1:0]   sum_r, sum_g, sum_b;
  logic [CNTW:0]   rem_r, rem_g, rem_b;
  logic [DCW-1:0]  div_cnt;
  logic [CNTW:0]   rs_r, rs_g, rs_b;
  logic            qb_r, qb_g, qb_b;

  assign job = q_head;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ring][wr_col] <= wr_pix;
    end
    rd_data <= mem[cur_ring][cur_x];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rbb_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    unique case (state)
      rbb_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = rbb_pkg::B_READ;
        end
      end
      rbb_pkg::B_READ: begin
        if (issue_done && !rd_pend) state_next = rbb_pkg::B_DIV;
      end
      rbb_pkg::B_DIV: begin
        if (div_cnt == DCW'(SW - 1)) state_next = rbb_pkg::B_OUT;
      end
      rbb_pkg::B_OUT: begin
        if (!out_stall) state_next = rbb_pkg::B_IDLE;
      end
      default: state_next = rbb_pkg::B_IDLE;
    endcase
  end

  assign issue = (state == rbb_pkg::B_READ) && !issue_done;

  always_comb begin
    rs_r = {rem_r[CNTW-1:0], sum_r[SW-1]};
    rs_g = {rem_g[CNTW-1:0], sum_g[SW-1]};
    rs_b = {rem_b[CNTW-1:0], sum_b[SW-1]};
    qb_r = rs_r >= (CNTW + 1)'(cnt);
    qb_g = rs_g >= (CNTW + 1)'(cnt);
    qb_b = rs_b >= (CNTW + 1)'(cnt);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend    <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      rd_pend <= issue;
      case (state)
        rbb_pkg::B_IDLE: begin
          if (q_pop) begin
            x0r        <= job.x0;
            x1r        <= job.x1;
            cur_x      <= job.x0;
            cur_ring   <= job.ring0;
            rows_left  <= job.nrow;
            last_r     <= job.last;
            issue_done <= 1'b0;
            cnt        <= '0;
            sum_r      <= '0;
            sum_g      <= '0;
            sum_b      <= '0;
            rem_r      <= '0;
            rem_g      <= '0;
            rem_b      <= '0;
            div_cnt    <= '0;
          end
        end
        rbb_pkg::B_READ: begin
          if (issue) begin
            if (cur_x == x1r) begin
              cur_x <= x0r;
              if (rows_left == '0) begin
                issue_done <= 1'b1;
              end else begin
                rows_left <= rows_left - KW'(1);
                cur_ring  <= (32'(cur_ring) == RING - 1) ? '0 : cur_ring + RW'(1);
              end
            end else begin
              cur_x <= cur_x + XW'(1);
            end
          end
          if (rd_pend) begin
            sum_r <= sum_r + SW'(rd_data[7:0]);
            sum_g <= sum_g + SW'(rd_data[15:8]);
            sum_b <= sum_b + SW'(rd_data[23:16]);
            cnt   <= cnt + CNTW'(1);
          end
        end
        rbb_pkg::B_DIV: begin
          rem_r   <= qb_r ? rs_r - (CNTW + 1)'(cnt) : rs_r;
          rem_g   <= qb_g ? rs_g - (CNTW + 1)'(cnt) : rs_g;
          rem_b   <= qb_b ? rs_b - (CNTW + 1)'(cnt) : rs_b;
          sum_r   <= {sum_r[SW-2:0], qb_r};
          sum_g   <= {sum_g[SW-2:0], qb_g};
          sum_b   <= {sum_b[SW-2:0], qb_b};
          div_cnt <= div_cnt + DCW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid              = (state == rbb_pkg::B_OUT);
  assign out_item.out_red       = sum_r[7:0];
  assign out_item.out_green     = sum_g[7:0];
  assign out_item.out_blue      = sum_b[7:0];
  assign out_item.last_of_frame = last_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == rbb_pkg::B_DIV |-> cnt != '0)
    else $error("window count is zero at divide");

  a_read_from_issue: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> $past(state) == rbb_pkg::B_READ)
    else $error("store read returned outside window pass");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    state == rbb_pkg::B_OUT && out_stall |=> state == rbb_pkg::B_OUT)
    else $error("result dropped while stalled");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == rbb_pkg::B_IDLE && !q_empty)
    else $error("job taken while busy");

endmodule

// ----- rtl/core/rgb_box_blur_unit.sv -----
// ----------------------------------------------------------------------------
// rgb_box_blur_unit: streaming k-by-k box blur on 8-bit RGB pixels
// Front end tracks positions and writes the line store; back end averages
// one window per output; a two-entry job queue sits between them.
//
//   channel   direction  handshake                word
//   cfg       in         cfg_we                   cfg_index, cfg_data
//   in        in         in_valid / in_stall      in_item (mode, red, green, blue)
//   out       out        out_valid / out_stall    out_item (red, green, blue, last)
//
// The back end handles one job at a time: it takes a job from the queue, reads
// the n pixels of its window (at most k*k), one line store read per pixel, then
// divides one quotient bit per cycle over SW, the sum width (16 at default
// size), and holds the result until out_stall is low.
// Reset is synchronous; the line store is not cleared and needs no sweep.
// in_stall rises only while the job queue is full; out_stall holds the result.
// ----------------------------------------------------------------------------
module rgb_box_blur_unit #(
  parameter int MAX_WIDTH  = rbb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rbb_pkg::MAX_HEIGHT_DEF,
  parameter int MAX_KERNEL = rbb_pkg::MAX_KERNEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbb_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  rbb_pkg::rbb_in_t               in_item,
  output logic                           out_valid,
  input  logic                           out_stall,
  output rbb_pkg::rbb_out_t              out_item
);

  localparam int JOB_W = rbb_pkg::job_bits(MAX_WIDTH, MAX_KERNEL);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(rbb_pkg::ring_rows(MAX_KERNEL));

  logic                      q_full, q_push, q_pop, q_empty;
  logic [JOB_W-1:0]          q_data, q_head;
  logic                      wr_en;
  logic [RW-1:0]             wr_ring;
  logic [XW-1:0]             wr_col;
  logic [rbb_pkg::PIX_W-1:0] wr_pix;

  rbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_KERNEL (MAX_KERNEL),
    .JOB_W      (JOB_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_data),
    .wr_en     (wr_en),
    .wr_ring   (wr_ring),
    .wr_col    (wr_col),
    .wr_pix    (wr_pix)
  );

  rbb_queue #(
    .DW (JOB_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  rbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_KERNEL (MAX_KERNEL),
    .JOB_W      (JOB_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_ring   (wr_ring),
    .wr_col    (wr_col),
    .wr_pix    (wr_pix),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
